// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int MODE_W       = 1;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int INDEX_W      = 11;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 5;

   localparam logic [MODE_W-1:0] MODE_PRINT = 1'b0;
   localparam logic [MODE_W-1:0] MODE_READ  = 1'b1;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h0f;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CHAR_W-1:0]  char_code;
      logic [ATTR_W-1:0]  attribute;
      logic               end_of_text;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_COL_W-1:0] cursor_col;
      logic [CURSOR_ROW_W-1:0] cursor_row;
      logic [CHAR_W-1:0]       cell_char;
      logic [ATTR_W-1:0]       cell_attr;
      logic                    scrolled;
   } rsp_type;

endpackage

// ===== hdl/text_console_writer_core.sv =====
// text screen store of ROWS x COLUMNS cells (character low byte, attribute
// high byte) with a working cursor and a displayed cursor
// request channel: req_valid / req_stall / req_data. mode 0 prints
// char_code with attribute at the working cursor (newline stores a space and
// moves to the next row); mode 1 reads the cell at cell_index
// response channel: rsp_valid / rsp_stall / rsp_data, one transaction per
// request, carrying the displayed cursor after the request
// sequencing: an accepted print or read goes to ST_RESP (through the scroll
// pass if it scrolls), which loads the response register once it is free;
// req_stall is high until the sequencer is back in ST_IDLE. the screen lives
// in a single-port-write, registered-read memory; a print that scrolls walks
// it with one address counter: each moved cell is read one row below, then
// written, and then the bottom row is written with blank cells
// reset: synchronous, active high. afterwards a clearing pass writes a blank
// cell (space, attribute 0x0f) to every entry, one per cycle; req_stall stays
// high during the pass
// back pressure: a finished response sits in the output register while
// rsp_stall is high; the next request may still be accepted, and its
// response waits until the register is free
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_data
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int DW    = CHAR_W + ATTR_W;

   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [DW-1:0] BLANK_CELL = {BLANK_ATTR, SPACE_CODE};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_BLANK,
      ST_RESP
   } state_type;

   // screen memory
   logic [DW-1:0] screen_mem [CELLS];
   logic [DW-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   // sequencer and cursor state
   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] work_col_ff, work_col_in;
   logic [RW-1:0] work_row_ff, work_row_in;
   logic [CW-1:0] shown_col_ff, shown_col_in;
   logic [RW-1:0] shown_row_ff, shown_row_in;
   logic          read_mode_ff, read_mode_in;
   logic          in_range_ff, in_range_in;
   logic          scrolled_ff, scrolled_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // helpers
   logic [31:0]   idx_wide;
   logic          idx_ok;
   logic [AW-1:0] cur_addr;
   logic [CW:0]   col_inc;
   logic [RW:0]   row_inc;
   logic          wrap_row;
   logic          do_scroll;
   logic [CW-1:0] new_col;
   logic [RW-1:0] new_row;
   logic [CHAR_W-1:0] put_char;
   logic [31:0]   col_wide;
   logic [31:0]   row_wide;

   assign idx_wide = 32'(req_data.cell_index);
   assign idx_ok   = idx_wide < 32'(CELLS);
   assign cur_addr = AW'(32'(work_row_ff) * 32'(COLUMNS) + 32'(work_col_ff));
   assign col_inc  = {1'b0, work_col_ff} + (CW+1)'(1);
   assign row_inc  = {1'b0, work_row_ff} + (RW+1)'(1);
   assign col_wide = 32'(shown_col_ff);
   assign row_wide = 32'(shown_row_ff);

   // cursor advance for a print: newline or column wrap moves to the next
   // row, and passing the last row means a scroll with the row held
   always_comb begin
      put_char = (req_data.char_code == NEWLINE_CODE) ? SPACE_CODE : req_data.char_code;
      wrap_row = (req_data.char_code == NEWLINE_CODE) ||
                 (col_inc == (CW+1)'(COLUMNS));
      if (wrap_row) begin
         new_col = '0;
      end else begin
         new_col = col_inc[CW-1:0];
      end
      do_scroll = wrap_row && (row_inc == (RW+1)'(ROWS));
      if (!wrap_row) begin
         new_row = work_row_ff;
      end else if (do_scroll) begin
         new_row = LAST_ROW;
      end else begin
         new_row = row_inc[RW-1:0];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      work_col_in  = work_col_ff;
      work_row_in  = work_row_ff;
      shown_col_in = shown_col_ff;
      shown_row_in = shown_row_ff;
      read_mode_in = read_mode_ff;
      in_range_in  = in_range_ff;
      scrolled_in  = scrolled_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = BLANK_CELL;
      mem_re       = 1'b0;
      mem_raddr    = idx_wide[AW-1:0];

      // response register drains when the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               read_mode_in = (req_data.mode == MODE_READ);
               in_range_in  = idx_ok;
               if (req_data.mode == MODE_PRINT) begin
                  mem_we      = 1'b1;
                  mem_waddr   = cur_addr;
                  mem_wdata   = {req_data.attribute, put_char};
                  work_col_in = new_col;
                  work_row_in = new_row;
                  scrolled_in = do_scroll;
                  if (req_data.end_of_text) begin
                     shown_col_in = new_col;
                     shown_row_in = new_row;
                  end
                  cnt_in   = '0;
                  state_in = do_scroll ? ST_SCR_RD : ST_RESP;
               end else begin
                  mem_re      = idx_ok;
                  scrolled_in = 1'b0;
                  state_in    = ST_RESP;
               end
            end
         end
         ST_SCR_RD: begin
            // fetch the cell one row below
            mem_re    = 1'b1;
            mem_raddr = cnt_ff + ROW_STEP;
            state_in  = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            cnt_in    = cnt_ff + AW'(1);
            state_in  = (cnt_ff == LAST_COPY) ? ST_BLANK : ST_SCR_RD;
         end
         ST_BLANK: begin
            // bottom row becomes blank cells
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.cursor_col = col_wide[CURSOR_COL_W-1:0];
               rsp_data_in.cursor_row = row_wide[CURSOR_ROW_W-1:0];
               if (read_mode_ff && in_range_ff) begin
                  rsp_data_in.cell_char = rd_data_ff[CHAR_W-1:0];
                  rsp_data_in.cell_attr = rd_data_ff[DW-1:CHAR_W];
               end else begin
                  rsp_data_in.cell_char = '0;
                  rsp_data_in.cell_attr = '0;
               end
               rsp_data_in.scrolled = scrolled_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         work_col_ff  <= '0;
         work_row_ff  <= '0;
         shown_col_ff <= '0;
         shown_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         work_col_ff  <= work_col_in;
         work_row_ff  <= work_row_in;
         shown_col_ff <= shown_col_in;
         shown_row_ff <= shown_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      read_mode_ff <= read_mode_in;
      in_range_ff  <= in_range_in;
      scrolled_ff  <= scrolled_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   // a request is never accepted in the cycle right after another one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // a scrolling response leaves the working cursor on the last row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.scrolled) |-> (work_row_ff == LAST_ROW))
      else $error("scroll without cursor on last row");

   // the working cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (32'(work_col_ff) < 32'(COLUMNS)) && (32'(work_row_ff) < 32'(ROWS)))
      else $error("working cursor off screen");

   // a read response never reports a scroll
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && read_mode_ff) |-> !scrolled_ff)
      else $error("read flagged as scroll");

endmodule
